// ===== rtl/alu16_pkg.sv =====
// ----------------------------------------------------------------------------
// alu16_pkg
// Shared types, flag positions and sizing constants for the pipelined ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package alu16_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int ACT_W          = 4;
    localparam int FLAGS_W        = 10;
    // Quotient bits resolved by each divider stage.
    localparam int DIV_STEPS      = 4;

    localparam int FLAG_GREATER  = 0;
    localparam int FLAG_LESSER   = 1;
    localparam int FLAG_EQUAL    = 2;
    localparam int FLAG_ZERO     = 3;
    localparam int FLAG_CARRY    = 4;
    localparam int FLAG_OVERFLOW = 5;
    localparam int FLAG_DIVZERO  = 6;
    localparam int FLAG_NEGATIVE = 9;

    typedef enum logic [ACT_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_AVG  = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_XOR  = 4'd8,
        OP_NOT  = 4'd9,
        OP_CMP  = 4'd10,
        OP_PASS = 4'd11
    } t_op;

    // Control that travels down the pipeline beside the data words.
    typedef struct packed {
        t_op                op;
        logic [FLAGS_W-1:0] flags;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== rtl/alu16_req_if.sv =====
// ----------------------------------------------------------------------------
// alu16_req_if
// Request channel of the ALU: operation, operands and carry selection.
// ----------------------------------------------------------------------------
`default_nettype none

interface alu16_req_if
    import alu16_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [DATA_WIDTH-1:0] operand_a;
    logic [DATA_WIDTH-1:0] operand_b;
    logic                  use_carry;
    logic                  carry_in;

    modport source (
        output valid, action, operand_a, operand_b, use_carry, carry_in,
        input  ready
    );

    modport sink (
        input  valid, action, operand_a, operand_b, use_carry, carry_in,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/alu16_rsp_if.sv =====
// ----------------------------------------------------------------------------
// alu16_rsp_if
// Response channel of the ALU: result word and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface alu16_rsp_if
    import alu16_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result;
    logic [FLAGS_W-1:0]    flags;

    modport source (
        output valid, result, flags,
        input  ready
    );

    modport sink (
        input  valid, result, flags,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/alu_16bit_with_status_flags.sv =====
// ----------------------------------------------------------------------------
// alu_16bit_with_status_flags
// Pipelined ALU with status flags: add with carry, subtract, multiply,
// divide, modulo, average, logic, compare and pass-through.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ---------------------------------------------------
//  i_req    in         action, operand_a, operand_b, use_carry, carry_in
//  o_rsp    out        result, flags
//
//  One beat is accepted every clock cycle unless a stall at o_rsp has
//  backed up to the input. Each beat passes through the front stage with
//  the multiplier and adders, one divider stage per four quotient bits, and
//  the output register. Synchronous active-low reset empties every stage.
//  A stall at o_rsp backs up only as far as the first empty stage, so
//  bubbles are squeezed out and nothing is dropped or repeated.
//
`default_nettype none

module alu_16bit_with_status_flags
    import alu16_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    alu16_req_if.sink   i_req,
    alu16_rsp_if.source o_rsp
);

    // Number of divider slices; the last one may resolve fewer bits.
    localparam int NDIV = (DATA_WIDTH + DIV_STEPS - 1) / DIV_STEPS;

    // Index k holds the outputs of the stage feeding divider slice k;
    // index NDIV feeds the output stage.
    logic                  s_valid [NDIV+1];
    logic                  s_ready [NDIV+1];
    t_ctrl                 s_ctrl  [NDIV+1];
    logic [DATA_WIDTH-1:0] s_res   [NDIV+1];
    logic [DATA_WIDTH-1:0] s_rem   [NDIV+1];
    logic [DATA_WIDTH-1:0] s_quo   [NDIV+1];
    logic [DATA_WIDTH-1:0] s_dvs   [NDIV+1];

    // The front stage computes every operation that finishes in one go and
    // loads the dividend and divisor for the divider slices.
    alu16_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_action    (i_req.action),
        .i_a         (i_req.operand_a),
        .i_b         (i_req.operand_b),
        .i_use_carry (i_req.use_carry),
        .i_carry_in  (i_req.carry_in),
        .o_valid     (s_valid[0]),
        .i_ready     (s_ready[0]),
        .o_ctrl      (s_ctrl[0]),
        .o_res       (s_res[0]),
        .o_quo       (s_quo[0]),
        .o_dvs       (s_dvs[0])
    );

    // The partial remainder starts from zero.
    assign s_rem[0] = '0;

    // Restoring divider, four quotient bits per slice.
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        localparam int STEPS = ((DATA_WIDTH - k * DIV_STEPS) < DIV_STEPS)
                             ? (DATA_WIDTH - k * DIV_STEPS) : DIV_STEPS;

        alu16_div_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .STEPS      (STEPS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_ctrl  (s_ctrl[k]),
            .i_res   (s_res[k]),
            .i_rem   (s_rem[k]),
            .i_quo   (s_quo[k]),
            .i_dvs   (s_dvs[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_ctrl  (s_ctrl[k+1]),
            .o_res   (s_res[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_quo   (s_quo[k+1]),
            .o_dvs   (s_dvs[k+1])
        );
    end

    // The output stage picks the divider result for divide and modulo,
    // handles a zero divisor and sets the zero flag.
    alu16_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid[NDIV]),
        .o_ready  (s_ready[NDIV]),
        .i_ctrl   (s_ctrl[NDIV]),
        .i_res    (s_res[NDIV]),
        .i_rem    (s_rem[NDIV]),
        .i_quo    (s_quo[NDIV]),
        .i_dvs    (s_dvs[NDIV]),
        .o_valid  (o_rsp.valid),
        .i_ready  (o_rsp.ready),
        .o_result (o_rsp.result),
        .o_flags  (o_rsp.flags)
    );

`ifndef ASSERT_OFF
    // The two unused flag bits never leave the block set.
    a_unused_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.flags[8:7] == 2'b00))
        else $error("unused flag bits set");

    // At most one compare outcome is reported.
    a_cmp_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> $onehot0(o_rsp.flags[FLAG_EQUAL:FLAG_GREATER]))
        else $error("more than one compare flag set");

    // A compare never reports zero.
    a_cmp_nozero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.flags[FLAG_EQUAL:FLAG_GREATER] != '0))
        |-> !o_rsp.flags[FLAG_ZERO])
        else $error("zero flag set on a compare");

    // Division by zero returns a zero result with the zero flag.
    a_divzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.flags[FLAG_DIVZERO])
        |-> ((o_rsp.result == '0) && o_rsp.flags[FLAG_ZERO]))
        else $error("divide-by-zero with non-zero result");

    // Back-pressure at the input only arises when the pipeline is full
    // and the output beat is stalled.
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (o_rsp.valid && !o_rsp.ready))
        else $error("input stalled while output can drain");
`endif

endmodule

`default_nettype wire

// ===== rtl/alu16_front.sv =====
// ----------------------------------------------------------------------------
// alu16_front
// First pipeline stage: every operation except divide and modulo, and the
// set-up of the divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module alu16_front
    import alu16_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [ACT_W-1:0]      i_action,
    input  wire logic [DATA_WIDTH-1:0] i_a,
    input  wire logic [DATA_WIDTH-1:0] i_b,
    input  wire logic                  i_use_carry,
    input  wire logic                  i_carry_in,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_ctrl                      o_ctrl,
    output logic [DATA_WIDTH-1:0]      o_res,
    output logic [DATA_WIDTH-1:0]      o_quo,
    output logic [DATA_WIDTH-1:0]      o_dvs
);

    logic                    r_valid;
    t_ctrl                   r_ctrl;
    logic [DATA_WIDTH-1:0]   r_res;
    logic [DATA_WIDTH-1:0]   r_quo;
    logic [DATA_WIDTH-1:0]   r_dvs;

    t_op                     n_op;
    logic [FLAGS_W-1:0]      n_flags;
    logic [DATA_WIDTH-1:0]   n_res;
    logic [DATA_WIDTH:0]     w_sum;
    logic [DATA_WIDTH:0]     w_add;
    logic [2*DATA_WIDTH-1:0] w_prod;
    logic                    w_cin;

    assign o_ready = !r_valid || i_ready;

    assign w_cin  = i_use_carry & i_carry_in;
    assign w_sum  = {1'b0, i_a} + {1'b0, i_b};
    assign w_add  = w_sum + {{DATA_WIDTH{1'b0}}, w_cin};
    assign w_prod = {{DATA_WIDTH{1'b0}}, i_a} * {{DATA_WIDTH{1'b0}}, i_b};

    always_comb begin
        n_op    = t_op'(i_action);
        n_flags = '0;
        n_res   = i_a;
        case (n_op)
            OP_ADD: begin
                n_res                = w_add[DATA_WIDTH-1:0];
                n_flags[FLAG_CARRY]  = w_add[DATA_WIDTH];
            end
            OP_SUB: begin
                n_res                  = i_a - i_b;
                n_flags[FLAG_NEGATIVE] = (i_a < i_b);
            end
            OP_MUL: begin
                n_res                  = w_prod[DATA_WIDTH-1:0];
                n_flags[FLAG_OVERFLOW] = |w_prod[2*DATA_WIDTH-1:DATA_WIDTH];
            end
            OP_AVG:  n_res = w_sum[DATA_WIDTH:1];
            OP_AND:  n_res = i_a & i_b;
            OP_OR:   n_res = i_a | i_b;
            OP_XOR:  n_res = i_a ^ i_b;
            OP_NOT:  n_res = ~i_a;
            OP_CMP: begin
                n_flags[FLAG_GREATER] = (i_a > i_b);
                n_flags[FLAG_LESSER]  = (i_a < i_b);
                n_flags[FLAG_EQUAL]   = (i_a == i_b);
            end
            default: n_res = i_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl.op    <= n_op;
            r_ctrl.flags <= n_flags;
            r_res        <= n_res;
            r_quo        <= i_a;
            r_dvs        <= i_b;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_res   = r_res;
    assign o_quo   = r_quo;
    assign o_dvs   = r_dvs;

endmodule

`default_nettype wire

// ===== rtl/alu16_div_stage.sv =====
// ----------------------------------------------------------------------------
// alu16_div_stage
// One registered slice of the restoring divider, resolving STEPS quotient
// bits, while the other results ride along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module alu16_div_stage
    import alu16_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int STEPS      = DIV_STEPS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_ctrl                 i_ctrl,
    input  wire logic [DATA_WIDTH-1:0] i_res,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_quo,
    input  wire logic [DATA_WIDTH-1:0] i_dvs,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_ctrl                      o_ctrl,
    output logic [DATA_WIDTH-1:0]      o_res,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_quo,
    output logic [DATA_WIDTH-1:0]      o_dvs
);

    logic                  r_valid;
    t_ctrl                 r_ctrl;
    logic [DATA_WIDTH-1:0] r_res;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_dvs;

    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_quo;

    assign o_ready = !r_valid || i_ready;

    // The partial remainder stays below a non-zero divisor, so the difference
    // always fits back into a data word.
    always_comb begin
        logic [DATA_WIDTH:0] sh;
        n_rem = i_rem;
        n_quo = i_quo;
        for (int s = 0; s < STEPS; s++) begin
            sh    = {n_rem, n_quo[DATA_WIDTH-1]};
            n_quo = {n_quo[DATA_WIDTH-2:0], 1'b0};
            if (sh >= {1'b0, i_dvs}) begin
                sh       = sh - {1'b0, i_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = sh[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= i_ctrl;
            r_res  <= i_res;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_dvs  <= i_dvs;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_res   = r_res;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dvs   = r_dvs;

endmodule

`default_nettype wire

// ===== rtl/alu16_back.sv =====
// ----------------------------------------------------------------------------
// alu16_back
// Final stage and output register: merges the divider result, adds the
// zero and divide-by-zero flags.
// ----------------------------------------------------------------------------
`default_nettype none

module alu16_back
    import alu16_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_ctrl                 i_ctrl,
    input  wire logic [DATA_WIDTH-1:0] i_res,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_quo,
    input  wire logic [DATA_WIDTH-1:0] i_dvs,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_WIDTH-1:0]      o_result,
    output logic [FLAGS_W-1:0]         o_flags
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_result;
    logic [FLAGS_W-1:0]    r_flags;

    logic [DATA_WIDTH-1:0] n_result;
    logic [FLAGS_W-1:0]    n_flags;
    logic                  w_is_div;
    logic                  w_dvs_zero;

    assign o_ready    = !r_valid || i_ready;
    assign w_is_div   = (i_ctrl.op == OP_DIV) || (i_ctrl.op == OP_MOD);
    assign w_dvs_zero = (i_dvs == '0);

    always_comb begin
        n_result = i_res;
        n_flags  = i_ctrl.flags;
        if (w_is_div) begin
            if (w_dvs_zero) begin
                n_result              = '0;
                n_flags[FLAG_DIVZERO] = 1'b1;
            end else if (i_ctrl.op == OP_DIV) begin
                n_result = i_quo;
            end else begin
                n_result = i_rem;
            end
        end
        if ((i_ctrl.op != OP_CMP) && (n_result == '0)) begin
            n_flags[FLAG_ZERO] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
            r_flags  <= n_flags;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_flags  = r_flags;

endmodule

`default_nettype wire
